// File: design/ppi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, constants and the arctangent table of the pose integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W = 5;
	localparam int CV_W = 34;
	localparam logic signed [CV_W-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [30:0] INV_TWO_PI_Q32 = 31'd683565276;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT_OLD,
		ST_MUL1,
		ST_MUL2,
		ST_UPD,
		ST_ROT_NEW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic mul1;
		logic mul2;
		logic upd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic rot_last;
	} stat_t;

	function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/ppi_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle while step is high, Q1.30 output.
// ----------------------------------------------------------------------------
module ppi_cordic import ppi_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   start,
	input  wire logic [31:0]            angle,
	input  wire logic                   step,
	output logic                        last,
	output logic signed [CV_W-1:0]      cos_o,
	output logic signed [CV_W-1:0]      sin_o
);

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [IW-1:0] LAST_I = IW'(STEPS - 1);

	logic signed [CV_W-1:0] x_q, y_q, z_q;
	logic [IW-1:0] i_q;
	logic flip_q;
	logic flip_in;
	logic [31:0] ang_f;
	logic signed [CV_W-1:0] atan_v;

	assign flip_in = angle[31] ^ angle[30];
	assign ang_f = flip_in ? (angle + 32'h8000_0000) : angle;
	assign atan_v = $signed({2'b00, atan_lookup(ATAN_IDX_W'(i_q))});
	assign last = (i_q == LAST_I);

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_X0;
			y_q <= '0;
			z_q <= CV_W'($signed(ang_f));
			i_q <= '0;
			flip_q <= flip_in;
		end else if (step) begin
			if (!z_q[CV_W-1]) begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + atan_v;
			end
			i_q <= i_q + 1'b1;
		end
	end

	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

// File: design/ppi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_datapath
// Pose state, velocity rotation products, heading update and output word.
// ----------------------------------------------------------------------------
module ppi_datapath import ppi_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output stat_t                   stat,
	input  wire logic signed [15:0] vel_x,
	input  wire logic signed [15:0] vel_y,
	input  wire logic signed [15:0] yaw_rate,
	input  wire logic [15:0]        time_step,
	output logic signed [31:0]      pos_x_out,
	output logic signed [31:0]      pos_y_out,
	output logic [15:0]             heading_out,
	output logic signed [15:0]      quat_z,
	output logic signed [15:0]      quat_w
);

	localparam logic signed [67:0] RND_D = 68'sd1 <<< 37;
	localparam logic signed [64:0] RND_H = 65'sd1 <<< 43;

	logic signed [31:0] pos_x_q, pos_y_q;
	logic [15:0] heading_q;
	logic signed [15:0] vx_q, vy_q, w_q;
	logic signed [16:0] ts_q;
	logic signed [49:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;
	logic signed [32:0] hp_q;
	logic signed [67:0] dx_q, dy_q;
	logic signed [64:0] hp2_q;
	logic signed [CV_W-1:0] c_v, s_v;
	logic rot_start;
	logic [31:0] rot_angle;
	logic signed [67:0] dxr, dyr;
	logic signed [64:0] dhr;
	logic [15:0] heading_n;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
			input logic signed [33:0] d);
		logic signed [34:0] r;
		r = 35'(p) + 35'(d);
		if (r > 35'sd2147483647) return 32'sh7FFF_FFFF;
		if (r < -35'sd2147483648) return 32'sh8000_0000;
		return r[31:0];
	endfunction

	function automatic logic signed [15:0] to_q14(input logic signed [CV_W-1:0] v);
		logic signed [CV_W-1:0] r;
		r = (v + 34'sd32768) >>> 16;
		if (r > 34'sd16384) return 16'sd16384;
		if (r < -34'sd16384) return -16'sd16384;
		return r[15:0];
	endfunction

	assign dxr = (dx_q + RND_D) >>> 38;
	assign dyr = (dy_q + RND_D) >>> 38;
	assign dhr = (hp2_q + RND_H) >>> 44;
	assign heading_n = heading_q + dhr[15:0];

	assign rot_start = cmd.accept | cmd.upd;
	assign rot_angle = cmd.upd ? {1'b0, heading_n, 15'd0} : {heading_q, 16'd0};

	ppi_cordic #(.STEPS(STEPS)) u_cordic (
		.clk   (clk),
		.start (rot_start),
		.angle (rot_angle),
		.step  (cmd.step),
		.last  (stat.rot_last),
		.cos_o (c_v),
		.sin_o (s_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			heading_q <= '0;
		end else if (cmd.upd) begin
			pos_x_q <= sat_add(pos_x_q, dxr[33:0]);
			pos_y_q <= sat_add(pos_y_q, dyr[33:0]);
			heading_q <= heading_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vx_q <= vel_x;
			vy_q <= vel_y;
			w_q <= yaw_rate;
			ts_q <= $signed({1'b0, time_step});
		end
		if (cmd.mul1) begin
			p_xc_q <= vx_q * c_v;
			p_ys_q <= vy_q * s_v;
			p_xs_q <= vx_q * s_v;
			p_yc_q <= vy_q * c_v;
			hp_q <= w_q * ts_q;
		end
		if (cmd.mul2) begin
			dx_q <= (51'(p_xc_q) - 51'(p_ys_q)) * ts_q;
			dy_q <= (51'(p_xs_q) + 51'(p_yc_q)) * ts_q;
			hp2_q <= hp_q * $signed({1'b0, INV_TWO_PI_Q32});
		end
		if (cmd.load_out) begin
			pos_x_out <= pos_x_q;
			pos_y_out <= pos_y_q;
			heading_out <= heading_q;
			quat_z <= to_q14(s_v);
			quat_w <= to_q14(c_v);
		end
	end

endmodule
`default_nettype wire

// File: design/ppi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_ctrl
// Sequencer for one update and the output word handshake.
// ----------------------------------------------------------------------------
module ppi_ctrl import ppi_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_n;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_ROT_OLD;
			ST_ROT_OLD: if (stat.rot_last) state_n = ST_MUL1;
			ST_MUL1: state_n = ST_MUL2;
			ST_MUL2: state_n = ST_UPD;
			ST_UPD: state_n = ST_ROT_NEW;
			ST_ROT_NEW: if (stat.rot_last) state_n = ST_DONE;
			ST_DONE: if (out_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			ST_ROT_OLD: cmd.step = 1'b1;
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_UPD: cmd.upd = 1'b1;
			ST_ROT_NEW: cmd.step = 1'b1;
			ST_DONE: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_ROT_OLD)
		else $error("accepted word did not start rotation");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("result word not presented");
	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("output valid rose outside done state");
`endif

endmodule
`default_nettype wire

// File: design/planar_pose_integrator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_pose_integrator_core
// Dead-reckoning pose integrator in the plane with CORDIC sine and cosine.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) takes one word of body-frame
// velocities, yaw rate and time step. The output channel (out_valid/out_ready)
// returns one word with the new position, heading and yaw quaternion parts.
// One word is in work at a time: a new word is not taken before the result of
// the last one has been loaded into the output register, since the iterative
// CORDIC unit makes two passes per word, one at the old and one at the new heading.
// Reset clears position and heading to zero and empties the output register.
// The output register holds a finished word while the receiver stalls, and
// the next input word is taken meanwhile; its result waits in the done state
// until the output register is free.
// ----------------------------------------------------------------------------
module planar_pose_integrator_core import ppi_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] vel_x,
	input  wire logic signed [15:0] vel_y,
	input  wire logic signed [15:0] yaw_rate,
	input  wire logic [15:0]        time_step,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      pos_x_out,
	output logic signed [31:0]      pos_y_out,
	output logic [15:0]             heading_out,
	output logic signed [15:0]      quat_z,
	output logic signed [15:0]      quat_w
);

	localparam int STEPS = (CORDIC_STEPS < 1) ? 1 :
		((CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS);

	cmd_t cmd;
	stat_t stat;

	ppi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ppi_datapath #(.STEPS(STEPS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.yaw_rate    (yaw_rate),
		.time_step   (time_step),
		.pos_x_out   (pos_x_out),
		.pos_y_out   (pos_y_out),
		.heading_out (heading_out),
		.quat_z      (quat_z),
		.quat_w      (quat_w)
	);

endmodule
`default_nettype wire

// File: sim/tb_planar_pose_integrator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_pose_integrator_core
// Self-checking bench for the dead-reckoning pose integrator. A driver feeds
// velocity words from a queue, a local fixed-point pose model predicts each
// result, and a monitor compares every output word with the prediction. The run
// covers field extremes, zero time steps, heading wrap and position saturation.
// ----------------------------------------------------------------------------
module tb_planar_pose_integrator_core;
	import ppi_pkg::*;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] wz;
		logic [15:0]        ts;
	} vel_word_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [15:0]        hd;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
	} pose_word_t;

	localparam longint ANGLE_TAB [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] vel_x = '0;
	logic signed [15:0] vel_y = '0;
	logic signed [15:0] yaw_rate = '0;
	logic [15:0] time_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x_out;
	logic signed [31:0] pos_y_out;
	logic [15:0] heading_out;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;

	vel_word_t pending_words[$];
	pose_word_t expected_poses[$];
	logic signed [31:0] model_px = '0;
	logic signed [31:0] model_py = '0;
	logic [15:0] model_hd = '0;
	int errors = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	bit quiet = 1'b0;

	planar_pose_integrator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vel_x(vel_x), .vel_y(vel_y), .yaw_rate(yaw_rate), .time_step(time_step),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_x_out(pos_x_out), .pos_y_out(pos_y_out), .heading_out(heading_out),
		.quat_z(quat_z), .quat_w(quat_w)
	);

	always #5 clk = ~clk;

	task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
		logic [1:0] q;
		bit flip;
		longint x, y, z, nx;
		q = ang[31:30];
		flip = (q == 2'd1) || (q == 2'd2);
		if (flip) ang = ang + 32'h8000_0000;
		z = longint'($signed(ang));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ANGLE_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ANGLE_TAB[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endtask

	function automatic logic signed [31:0] clamp_add(input logic signed [31:0] p,
			input longint d);
		longint r;
		r = longint'(p) + d;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic logic signed [15:0] half_angle_q14(input longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r[15:0];
	endfunction

	task automatic integrate_pose(input vel_word_t w);
		longint c, s, vx, vy, wz, ts, dx, dy, dh;
		pose_word_t p;
		vx = w.vx;
		vy = w.vy;
		wz = w.wz;
		ts = longint'({48'd0, w.ts});
		sin_cos({model_hd, 16'd0}, c, s);
		dx = (vx * c - vy * s) * ts;
		dy = (vx * s + vy * c) * ts;
		model_px = clamp_add(model_px, (dx + (64'sd1 <<< 37)) >>> 38);
		model_py = clamp_add(model_py, (dy + (64'sd1 <<< 37)) >>> 38);
		dh = (wz * ts * 683565276 + (64'sd1 <<< 43)) >>> 44;
		model_hd = model_hd + dh[15:0];
		sin_cos({1'b0, model_hd, 15'd0}, c, s);
		p.px = model_px;
		p.py = model_py;
		p.hd = model_hd;
		p.qz = half_angle_q14(s);
		p.qw = half_angle_q14(c);
		expected_poses.push_back(p);
	endtask

	task automatic push_word(input int vx, input int vy, input int wz, input int ts);
		vel_word_t w;
		w.vx = vx[15:0];
		w.vy = vy[15:0];
		w.wz = wz[15:0];
		w.ts = ts[15:0];
		pending_words.push_back(w);
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			integrate_pose('{vel_x, vel_y, yaw_rate, time_step});
		end
		if (!in_valid || in_ready) begin
			if (tx_idle > 0) begin
				tx_idle <= tx_idle - 1;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				tx_idle <= $urandom_range(1, 18);
				in_valid <= 1'b0;
			end else if (arst_n && pending_words.size() > 0) begin
				vel_word_t w;
				w = pending_words.pop_front();
				vel_x <= w.vx;
				vel_y <= w.vy;
				yaw_rate <= w.wz;
				time_step <= w.ts;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			pose_word_t got, want;
			got = '{pos_x_out, pos_y_out, heading_out, quat_z, quat_w};
			if (expected_poses.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output word %h", got);
			end else begin
				want = expected_poses.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("word mismatch: px %0d/%0d py %0d/%0d hd %0d/%0d qz %0d/%0d qw %0d/%0d",
							want.px, got.px, want.py, got.py, want.hd, got.hd,
							want.qz, got.qz, want.qw, got.qw);
				end
			end
		end
		if (rx_idle > 0) begin
			rx_idle <= rx_idle - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			rx_idle <= $urandom_range(1, 18);
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	initial begin
		#20_000_000;
		$display("planar_pose_integrator_core: mismatch");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		push_word(0, 0, 0, 0);
		push_word(32767, 32767, 32767, 0);
		push_word(32767, -32768, 0, 65535);
		push_word(-32768, 32767, 0, 65535);
		push_word(256, 0, 32767, 65535);
		push_word(256, 256, 32767, 65535);
		push_word(0, 256, -32768, 65535);
		push_word(-32768, -32768, -32768, 65535);
		push_word(100, -100, 6434, 65535);
		push_word(100, 100, 6434, 65535);
		push_word(100, 100, 6434, 65535);
		push_word(100, 100, 6434, 65535);
		push_word(0, 0, 1, 1);
		push_word(0, 0, -1, 1);
		push_word(-1, -1, -1, 65535);
		push_word(1, 1, 1, 32768);
		push_word(32767, 0, 12868, 65535);
		push_word(12345, -5432, -12868, 40000);
		push_word(-32768, 32767, 32767, 65535);
		push_word(5, 5, 5, 0);
		while (pending_words.size() > 0 || in_valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		push_word(0, 0, -model_hd, 65535);
		for (int i = 0; i < 260; i++)
			push_word(32767 - $urandom_range(0, 3), 32767 - $urandom_range(0, 3), 0,
				65535 - $urandom_range(0, 7));
		for (int i = 0; i < 520; i++)
			push_word(-32768 + $urandom_range(0, 3), -32768 + $urandom_range(0, 3), 0,
				65535 - $urandom_range(0, 7));
		for (int i = 0; i < 300; i++) begin
			if ($urandom_range(0, 3) == 0)
				push_word($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 15));
			else
				push_word($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
		end
		while (pending_words.size() > 100) @(posedge clk);
		quiet = 1'b1;
		while (pending_words.size() > 0 || in_valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("planar_pose_integrator_core: match");
		end else begin
			$display("planar_pose_integrator_core: mismatch");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/ppi_pkg.sv
design/ppi_cordic.sv
design/ppi_datapath.sv
design/ppi_ctrl.sv
design/planar_pose_integrator_core.sv
sim/tb_planar_pose_integrator_core.sv
